[rtl/gsv_pkg.sv]
// ----------------------------------------------------------------------------
// gsv_pkg
// types, constants and helpers shared by the gif structure validator files
// ----------------------------------------------------------------------------
package gsv_pkg;

  // buffer limit: the byte offset saturates here
  localparam int unsigned MAX_BUFFER_BYTES = 65536;
  localparam int unsigned OFFSET_W         = $clog2(MAX_BUFFER_BYTES + 1);

  localparam int unsigned FILE_SIZE_W = 17;
  localparam int unsigned SKIP_W      = 10;
  localparam int unsigned DIM_W       = 16;

  // configuration port
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = CFG_ADDR_W - 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIMENSION = '0;
  localparam logic [DIM_W-1:0]       MAX_DIMENSION_RESET = 16'd16384;

  typedef logic [7:0]             byte_t;
  typedef logic [FILE_SIZE_W-1:0] size_t;
  typedef logic [OFFSET_W-1:0]    offset_t;
  typedef logic [SKIP_W-1:0]      skip_t;
  typedef logic [DIM_W-1:0]       dim_t;

  typedef enum logic [1:0] {
    VERDICT_REJECT      = 2'd0,
    VERDICT_HEADER_ONLY = 2'd1,
    VERDICT_IMAGE       = 2'd2,
    VERDICT_TRAILER     = 2'd3
  } verdict_t;

  // block introducers and flags
  localparam byte_t BYTE_TRAILER   = 8'h3B;
  localparam byte_t BYTE_IMAGE_SEP = 8'h2C;
  localparam byte_t BYTE_EXT_INTRO = 8'h21;
  localparam byte_t TABLE_FLAG     = 8'h80;
  localparam byte_t TABLE_SIZE_MSK = 8'h07;
  localparam skip_t IMG_DESC_BYTES = 10'd8;

  // signature bytes
  localparam byte_t SIG_G   = 8'h47;
  localparam byte_t SIG_I   = 8'h49;
  localparam byte_t SIG_F   = 8'h46;
  localparam byte_t SIG_8   = 8'h38;
  localparam byte_t SIG_7   = 8'h37;
  localparam byte_t SIG_9   = 8'h39;
  localparam byte_t SIG_A   = 8'h61;

  // result handed from the parser to the output queue
  typedef struct packed {
    logic     valid;
    verdict_t verdict;
    size_t    file_size;
  } result_t;

  // colour table length: 3 << (n + 1)
  function automatic skip_t table_bytes(input byte_t packed_byte);
    logic [3:0] sh;
    sh = {1'b0, packed_byte[2:0] & TABLE_SIZE_MSK[2:0]} + 4'd1;
    return skip_t'(10'd3 << sh);
  endfunction

endpackage

[rtl/gsv_in_if.sv]
// ----------------------------------------------------------------------------
// gsv_in_if
// byte stream channel into the validator
// ----------------------------------------------------------------------------
interface gsv_in_if;
  import gsv_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/gsv_out_if.sv]
// ----------------------------------------------------------------------------
// gsv_out_if
// verdict channel out of the validator
// ----------------------------------------------------------------------------
interface gsv_out_if;
  import gsv_pkg::*;

  logic     valid;
  logic     ready;
  verdict_t verdict;
  size_t    file_size;

  modport source (output valid, output verdict, output file_size, input ready);
  modport sink   (input valid, input verdict, input file_size, output ready);
endinterface

[rtl/gif_structure_validator.sv]
// ----------------------------------------------------------------------------
// gif_structure_validator
// streaming gif87a / gif89a block structure check, when not stalled one byte per clock
// ----------------------------------------------------------------------------
// Bytes of a candidate buffer enter on in_chan, one per transfer, with
// last_byte set on the final one. The block checks the signature and the
// screen descriptor, skips colour tables, walks image descriptors,
// extensions and their sub-blocks, and sends exactly one verdict per buffer
// on out_chan: at the byte that decides it or at the last byte. A new byte
// is taken every clock while the input is not stalled; the whole per-byte
// state update is done in the parser stage, so the sustained rate is one
// byte per cycle when not stalled. A verdict is decided on the byte held in
// the input register and is registered in the output register, or in its
// skid entry, before its transfer on out_chan. Input stalls only while a
// byte waits in the input register and the output register and its skid
// entry are both full. max_dimension is written over the apb-style port at
// byte address 0 and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module gif_structure_validator (
  input  logic                          clk,
  input  logic                          rst_n,
  gsv_in_if.sink                        in_chan,
  gsv_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gsv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gsv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gsv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import gsv_pkg::*;

  dim_t    max_dim_r;
  logic    cfg_write;
  logic    room;
  result_t result;
  logic [CFG_INDEX_W-1:0] reg_index;

  // register file: a single 16-bit limit, no wait states
  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == REG_MAX_DIMENSION) ?
                     CFG_DATA_W'(max_dim_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r <= MAX_DIMENSION_RESET;
    end else if (cfg_write && (reg_index == REG_MAX_DIMENSION)) begin
      max_dim_r <= pwdata[DIM_W-1:0];
    end
  end

  // byte parser: input register plus per-byte state update
  gsv_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .max_dimension (max_dim_r),
    .room          (room),
    .result        (result)
  );

  // verdict output register with skid entry
  gsv_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .result   (result),
    .room     (room),
    .out_chan (out_chan)
  );

  // input held off only while results are backed up
  a_stall_needs_backlog : assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no verdict waiting");

  // only a trailer verdict carries a size
  a_size_only_on_trailer : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.verdict != VERDICT_TRAILER) |-> out_chan.file_size == '0)
    else $error("file size on a non-trailer verdict");

  // a trailer verdict has a nonzero size
  a_trailer_size : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.verdict == VERDICT_TRAILER) |-> out_chan.file_size != '0)
    else $error("trailer verdict with zero size");

  // limit register takes the written value
  a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write && (reg_index == REG_MAX_DIMENSION) |=> max_dim_r == $past(pwdata[DIM_W-1:0]))
    else $error("max dimension write lost");

endmodule

[rtl/gsv_parser.sv]
// ----------------------------------------------------------------------------
// gsv_parser
// input register and gif block walk, one byte per cycle when not stalled
// ----------------------------------------------------------------------------
module gsv_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  gsv_in_if.sink               in_chan,
  input  gsv_pkg::dim_t        max_dimension,
  input  logic                 room,
  output gsv_pkg::result_t     result
);
  import gsv_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_GCT       = 4'd1,
    PH_BLOCK     = 4'd2,
    PH_IMG_DESC  = 4'd3,
    PH_IMG_PACK  = 4'd4,
    PH_LCT       = 4'd5,
    PH_LZW       = 4'd6,
    PH_SUB_SIZE  = 4'd7,
    PH_SUB_DATA  = 4'd8,
    PH_EXT_LABEL = 4'd9
  } phase_t;

  // header byte positions
  localparam logic [3:0] HDR_SIG0  = 4'd0;
  localparam logic [3:0] HDR_SIG1  = 4'd1;
  localparam logic [3:0] HDR_SIG2  = 4'd2;
  localparam logic [3:0] HDR_SIG3  = 4'd3;
  localparam logic [3:0] HDR_SIG4  = 4'd4;
  localparam logic [3:0] HDR_SIG5  = 4'd5;
  localparam logic [3:0] HDR_W_LO  = 4'd6;
  localparam logic [3:0] HDR_W_HI  = 4'd7;
  localparam logic [3:0] HDR_H_LO  = 4'd8;
  localparam logic [3:0] HDR_H_HI  = 4'd9;
  localparam logic [3:0] HDR_PACK  = 4'd10;
  localparam offset_t    HDR_LAST  = OFFSET_W'(12);
  localparam offset_t    OFF_LIMIT = OFFSET_W'(MAX_BUFFER_BYTES);

  // input register
  logic    s1_valid_r;
  byte_t   s1_byte_r;
  logic    s1_last_r;

  // parse state
  phase_t  phase_r, phase_nxt;
  offset_t offset_r, offset_nxt;
  skip_t   skip_r, skip_nxt;
  byte_t   dim_low_r, dim_low_nxt;
  logic    image_seen_r, image_seen_nxt;
  logic    given_r, given_nxt;

  logic     fire;
  logic     decided;
  verdict_t code;
  dim_t     dim;
  skip_t    skip_dec;
  offset_t  size_capped;

  assign fire          = s1_valid_r && room;
  assign in_chan.ready = !s1_valid_r || room;

  assign dim         = {s1_byte_r, dim_low_r};
  assign skip_dec    = (skip_r != '0) ? skip_r - skip_t'(1) : skip_r;
  assign size_capped = (offset_r >= OFF_LIMIT) ? OFF_LIMIT : offset_r + offset_t'(1);

  always_comb begin
    phase_nxt      = phase_r;
    skip_nxt       = skip_r;
    dim_low_nxt    = dim_low_r;
    image_seen_nxt = image_seen_r;
    given_nxt      = given_r;
    decided        = 1'b0;
    code           = VERDICT_REJECT;

    if (!given_r) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (offset_r < HDR_LAST) begin
            unique case (offset_r[3:0])
              HDR_SIG0: decided = (s1_byte_r != SIG_G);
              HDR_SIG1: decided = (s1_byte_r != SIG_I);
              HDR_SIG2: decided = (s1_byte_r != SIG_F);
              HDR_SIG3: decided = (s1_byte_r != SIG_8);
              HDR_SIG4: decided = (s1_byte_r != SIG_7) && (s1_byte_r != SIG_9);
              HDR_SIG5: decided = (s1_byte_r != SIG_A);
              HDR_W_LO, HDR_H_LO: dim_low_nxt = s1_byte_r;
              HDR_W_HI, HDR_H_HI: decided = (dim == '0) || (dim > max_dimension);
              HDR_PACK: begin
                skip_nxt = ((s1_byte_r & TABLE_FLAG) != '0) ? table_bytes(s1_byte_r) : '0;
              end
              default: ;
            endcase
          end else begin
            phase_nxt = (skip_r != '0) ? PH_GCT : PH_BLOCK;
          end
        end
        PH_GCT, PH_IMG_DESC, PH_LCT, PH_SUB_DATA: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            unique case (phase_r)
              PH_GCT:      phase_nxt = PH_BLOCK;
              PH_IMG_DESC: phase_nxt = PH_IMG_PACK;
              PH_LCT:      phase_nxt = PH_LZW;
              default:     phase_nxt = PH_SUB_SIZE;
            endcase
          end
        end
        PH_IMG_PACK: begin
          if ((s1_byte_r & TABLE_FLAG) != '0) begin
            skip_nxt  = table_bytes(s1_byte_r);
            phase_nxt = PH_LCT;
          end else begin
            phase_nxt = PH_LZW;
          end
        end
        PH_LZW, PH_EXT_LABEL: phase_nxt = PH_SUB_SIZE;
        PH_SUB_SIZE: begin
          if (s1_byte_r == '0) begin
            phase_nxt = PH_BLOCK;
          end else begin
            skip_nxt  = skip_t'(s1_byte_r);
            phase_nxt = PH_SUB_DATA;
          end
        end
        default: begin
          // block walk, also taken by the unused phase codes
          priority if (s1_byte_r == BYTE_TRAILER) begin
            decided = 1'b1;
            code    = VERDICT_TRAILER;
          end else if (s1_byte_r == BYTE_IMAGE_SEP) begin
            image_seen_nxt = 1'b1;
            skip_nxt       = IMG_DESC_BYTES;
            phase_nxt      = PH_IMG_DESC;
          end else if (s1_byte_r == BYTE_EXT_INTRO) begin
            phase_nxt = PH_EXT_LABEL;
          end else begin
            phase_nxt = phase_r;
          end
        end
      endcase

      // end of buffer without an earlier answer
      if (!decided && s1_last_r) begin
        decided = 1'b1;
        if (phase_nxt == PH_HEADER) begin
          code = VERDICT_REJECT;
        end else begin
          code = image_seen_nxt ? VERDICT_IMAGE : VERDICT_HEADER_ONLY;
        end
      end
      if (decided) begin
        given_nxt = 1'b1;
      end
    end

    offset_nxt = (offset_r < OFF_LIMIT) ? offset_r + offset_t'(1) : offset_r;

    if (s1_last_r) begin
      phase_nxt      = PH_HEADER;
      offset_nxt     = '0;
      skip_nxt       = '0;
      dim_low_nxt    = '0;
      image_seen_nxt = 1'b0;
      given_nxt      = 1'b0;
    end
  end

  always_comb begin
    result.valid     = fire && !given_r && decided;
    result.verdict   = code;
    result.file_size = (code == VERDICT_TRAILER) ? FILE_SIZE_W'(size_capped) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      phase_r      <= PH_HEADER;
      offset_r     <= '0;
      skip_r       <= '0;
      dim_low_r    <= '0;
      image_seen_r <= 1'b0;
      given_r      <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        phase_r      <= phase_nxt;
        offset_r     <= offset_nxt;
        skip_r       <= skip_nxt;
        dim_low_r    <= dim_low_nxt;
        image_seen_r <= image_seen_nxt;
        given_r      <= given_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

endmodule

[rtl/gsv_out_queue.sv]
// ----------------------------------------------------------------------------
// gsv_out_queue
// output register with a skid entry behind it
// ----------------------------------------------------------------------------
module gsv_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  gsv_pkg::result_t result,
  output logic             room,
  gsv_out_if.source        out_chan
);
  import gsv_pkg::*;

  logic     out_valid_r;
  verdict_t out_verdict_r;
  size_t    out_size_r;
  logic     skid_valid_r;
  verdict_t skid_verdict_r;
  size_t    skid_size_r;
  logic     pop;

  assign room               = !skid_valid_r;
  assign pop                = out_valid_r && out_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.verdict   = out_verdict_r;
  assign out_chan.file_size = out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= result.valid;
        end
      end else if (result.valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_verdict_r <= skid_verdict_r;
        out_size_r    <= skid_size_r;
      end else if (result.valid) begin
        out_verdict_r <= result.verdict;
        out_size_r    <= result.file_size;
      end
    end else if (result.valid) begin
      skid_verdict_r <= result.verdict;
      skid_size_r    <= result.file_size;
    end
  end

endmodule
